// File: rtl/dual_motor_speed_curve_drive_macros.svh
`ifndef DUAL_MOTOR_SPEED_CURVE_DRIVE_MACROS_SVH
`define DUAL_MOTOR_SPEED_CURVE_DRIVE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define DMSCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dmscd check failed");

// Next-cycle implication, clocked on i_clk, off during reset
`define DMSCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dmscd check failed");

`endif

// File: rtl/dmscd_pkg.sv
package dmscd_pkg;

    localparam int DUTY_BITS    = 10;
    localparam int CURVE_POINTS = 11;
    localparam int PCT_STEP     = 10;
    localparam int FULL_PCT     = (CURVE_POINTS - 1) * PCT_STEP;
    localparam int TAB_DEPTH    = FULL_PCT;
    localparam int TAB_IDX_W    = $clog2(TAB_DEPTH);
    localparam int CMD_W        = 3;
    localparam int SPD_W        = 8;

    typedef logic [DUTY_BITS-1:0] t_duty;
    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [SPD_W-1:0]     t_spd;

    localparam t_duty DUTY_MAX = '1;

    localparam t_cmd CMD_STOP     = 3'd0;
    localparam t_cmd CMD_FORWARD  = 3'd1;
    localparam t_cmd CMD_BACKWARD = 3'd2;
    localparam t_cmd CMD_LEFT     = 3'd3;
    localparam t_cmd CMD_RIGHT    = 3'd4;

    typedef struct packed {
        logic a_in1;
        logic a_in2;
        logic b_in1;
        logic b_in2;
    } t_bridge;

    typedef int    t_pts [CURVE_POINTS];
    typedef t_duty t_tab [TAB_DEPTH];

    localparam t_pts LEFT_PTS  = '{0, 100, 200, 300, 400, 500, 600, 700, 800, 900, 1023};
    localparam t_pts RIGHT_PTS = '{0, 50, 150, 200, 350, 500, 550, 700, 770, 880, 1023};

    // Expand a break-point curve into one entry per percent; division truncates
    function automatic t_tab build_tab(t_pts pts);
        t_tab tab;
        int   seg;
        int   rem;
        int   dy;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            seg    = i / PCT_STEP;
            rem    = i % PCT_STEP;
            dy     = pts[seg + 1] - pts[seg];
            tab[i] = DUTY_BITS'(pts[seg] + (rem * dy) / PCT_STEP);
        end
        return tab;
    endfunction

    localparam t_tab LEFT_TAB  = build_tab(LEFT_PTS);
    localparam t_tab RIGHT_TAB = build_tab(RIGHT_PTS);

endpackage

// File: rtl/dmscd_map.sv
module dmscd_map
    import dmscd_pkg::*;
(
    input  t_cmd    i_cmd,
    input  t_spd    i_spd,
    output t_bridge o_bridge,
    output t_duty   o_duty_a,
    output t_duty   o_duty_b
);

    logic                 full;
    logic [TAB_IDX_W-1:0] idx;
    t_duty                duty_l;
    t_duty                duty_r;

    always_comb begin
        full   = (i_spd >= SPD_W'(FULL_PCT));
        idx    = full ? '0 : TAB_IDX_W'(i_spd);
        duty_l = full ? DUTY_MAX : LEFT_TAB[idx];
        duty_r = full ? DUTY_MAX : RIGHT_TAB[idx];
    end

    always_comb begin
        o_bridge = '0;
        o_duty_a = '0;
        o_duty_b = '0;
        unique case (i_cmd)
            CMD_FORWARD: begin
                o_bridge.a_in1 = 1'b1;
                o_bridge.b_in1 = 1'b1;
                o_duty_a       = duty_r;
                o_duty_b       = duty_l;
            end
            CMD_BACKWARD: begin
                o_bridge.a_in2 = 1'b1;
                o_bridge.b_in2 = 1'b1;
                o_duty_a       = duty_l;
                o_duty_b       = duty_r;
            end
            CMD_LEFT: begin
                o_bridge.b_in1 = 1'b1;
                o_duty_b       = duty_r;
            end
            CMD_RIGHT: begin
                o_bridge.a_in1 = 1'b1;
                o_duty_a       = duty_l;
            end
            default: begin
                // stop and unknown codes: all lines low, no duty
                o_bridge = '0;
            end
        endcase
    end

endmodule

// File: rtl/dual_motor_speed_curve_drive.sv
// Takes one request per cycle while o_ready is high and returns its bridge levels and duties
// through an input register, then two constant curve tables of one entry per percent and a
// command select, then the result register. Under output back-pressure it holds two requests
// (one in each register) and only then drops o_ready. Speeds of 100 and above give full duty.
`include "dual_motor_speed_curve_drive_macros.svh"

module dual_motor_speed_curve_drive
    import dmscd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [SPD_W-1:0]     i_speed_pct,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_a_in1,
    output logic                 o_a_in2,
    output logic                 o_b_in1,
    output logic                 o_b_in2,
    output logic [DUTY_BITS-1:0] o_duty_a,
    output logic [DUTY_BITS-1:0] o_duty_b
);

    logic    r_s1_valid;
    logic    n_s1_valid;
    t_cmd    r_s1_cmd;
    t_spd    r_s1_spd;
    logic    r_s2_valid;
    logic    n_s2_valid;
    t_bridge r_bridge;
    t_duty   r_duty_a;
    t_duty   r_duty_b;

    logic    adv1;
    logic    adv2;
    t_bridge map_bridge;
    t_duty   map_duty_a;
    t_duty   map_duty_b;

    dmscd_map u_map (
        .i_cmd    (r_s1_cmd),
        .i_spd    (r_s1_spd),
        .o_bridge (map_bridge),
        .o_duty_a (map_duty_a),
        .o_duty_b (map_duty_b)
    );

    // advance the result stage when empty or being drained
    assign adv2    = !r_s2_valid || i_ready;
    assign adv1    = !r_s1_valid || adv2;
    assign o_ready = adv1;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s2_valid = r_s2_valid;
        if (adv2) begin
            n_s2_valid = r_s1_valid;
        end
        if (adv1) begin
            n_s1_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_s1_cmd <= i_command;
            r_s1_spd <= i_speed_pct;
        end
        if (adv2 && r_s1_valid) begin
            r_bridge <= map_bridge;
            r_duty_a <= map_duty_a;
            r_duty_b <= map_duty_b;
        end
    end

    assign o_valid  = r_s2_valid;
    assign o_a_in1  = r_bridge.a_in1;
    assign o_a_in2  = r_bridge.a_in2;
    assign o_b_in1  = r_bridge.b_in1;
    assign o_b_in2  = r_bridge.b_in2;
    assign o_duty_a = r_duty_a;
    assign o_duty_b = r_duty_b;

    `DMSCD_ASSERT_NOW(a_no_shoot, o_valid, !(o_a_in1 && o_a_in2) && !(o_b_in1 && o_b_in2))
    `DMSCD_ASSERT_NEXT(a_stop_quiet, adv2 && r_s1_valid && r_s1_cmd == CMD_STOP,
        !o_a_in1 && !o_a_in2 && !o_b_in1 && !o_b_in2 && o_duty_a == '0 && o_duty_b == '0)
    `DMSCD_ASSERT_NEXT(a_full_fwd, adv2 && r_s1_valid && r_s1_cmd == CMD_FORWARD &&
        r_s1_spd >= SPD_W'(FULL_PCT), o_duty_a == DUTY_MAX && o_duty_b == DUTY_MAX)
    `DMSCD_ASSERT_NOW(a_a_idle_zero, o_valid && !o_a_in1 && !o_a_in2, o_duty_a == '0)
    `DMSCD_ASSERT_NOW(a_b_idle_zero, o_valid && !o_b_in1 && !o_b_in2, o_duty_b == '0)

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import dmscd_pkg::*;

    localparam int  RANDOM_REQUESTS = 1900;
    localparam int  CYCLE_LIMIT     = 400000;
    localparam int  DRAIN_CYCLES    = 8;
    localparam int  PROBE_COUNT     = 23;

    // commands outside the decoded set, all acting as stop
    localparam t_cmd CMD_SPARE5 = 3'd5;
    localparam t_cmd CMD_SPARE6 = 3'd6;
    localparam t_cmd CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic  a_in1;
        logic  a_in2;
        logic  b_in1;
        logic  b_in2;
        t_duty duty_a;
        t_duty duty_b;
    } t_drive;

    typedef struct packed {
        t_cmd   cmd;
        t_spd   spd;
        logic   typed;
        t_drive want;
    } t_probe;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_ready     = 1'b0;
    logic [2:0]  i_command   = '0;
    logic [7:0]  i_speed_pct = '0;
    logic        o_ready;
    logic        o_valid;
    logic        o_a_in1;
    logic        o_a_in2;
    logic        o_b_in1;
    logic        o_b_in2;
    t_duty       o_duty_a;
    t_duty       o_duty_b;

    int          left_knees  [11] = '{0, 100, 200, 300, 400, 500, 600, 700, 800, 900, 1023};
    int          right_knees [11] = '{0, 50, 150, 200, 350, 500, 550, 700, 770, 880, 1023};

    t_drive      pending_drive_q [$];
    t_drive      got_drive;
    t_drive      want_drive;
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    logic [9:0]  stall_phase = '0;

    // command, speed, typed flag, then pin pattern, duty A, duty B (computed when typed is 0)
    t_probe probe_tab [PROBE_COUNT] = '{
        '{CMD_STOP,     8'd0,   1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 10'd0,    10'd0}},
        '{CMD_FORWARD,  8'd0,   1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 10'd0,    10'd0}},
        '{CMD_FORWARD,  8'd100, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 10'd1023, 10'd1023}},
        '{CMD_BACKWARD, 8'd255, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 10'd1023, 10'd1023}},
        '{CMD_LEFT,     8'd100, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 10'd0,    10'd1023}},
        '{CMD_LEFT,     8'd255, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 10'd0,    10'd1023}},
        '{CMD_RIGHT,    8'd200, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 10'd1023, 10'd0}},
        '{CMD_RIGHT,    8'd0,   1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 10'd0,    10'd0}},
        '{CMD_SPARE5,   8'd100, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 10'd0,    10'd0}},
        '{CMD_SPARE7,   8'd255, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 10'd0,    10'd0}},
        '{CMD_STOP,     8'd255, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 10'd0,    10'd0}},
        '{CMD_FORWARD,  8'd50,  1'b0, '0},
        '{CMD_FORWARD,  8'd99,  1'b0, '0},
        '{CMD_FORWARD,  8'd101, 1'b0, '0},
        '{CMD_BACKWARD, 8'd1,   1'b0, '0},
        '{CMD_BACKWARD, 8'd10,  1'b0, '0},
        '{CMD_BACKWARD, 8'd45,  1'b0, '0},
        '{CMD_BACKWARD, 8'd85,  1'b0, '0},
        '{CMD_LEFT,     8'd33,  1'b0, '0},
        '{CMD_LEFT,     8'd90,  1'b0, '0},
        '{CMD_RIGHT,    8'd9,   1'b0, '0},
        '{CMD_RIGHT,    8'd77,  1'b0, '0},
        '{CMD_SPARE6,   8'd60,  1'b0, '0}
    };

    dual_motor_speed_curve_drive i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_speed_pct (i_speed_pct),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_a_in1     (o_a_in1),
        .o_a_in2     (o_a_in2),
        .o_b_in1     (o_b_in1),
        .o_b_in2     (o_b_in2),
        .o_duty_a    (o_duty_a),
        .o_duty_b    (o_duty_b)
    );

    always #5 i_clk = ~i_clk;

    // Interpolate one curve over 10-percent segments, truncating; speeds of 100 and above give full duty
    function automatic t_duty curve_duty(input logic use_right, input t_spd spd);
        int seg;
        int offs;
        int y0;
        int y1;
        if (spd >= 8'd100) begin
            return DUTY_MAX;
        end
        seg  = spd / 10;
        offs = spd - seg * 10;
        y0   = use_right ? right_knees[seg]     : left_knees[seg];
        y1   = use_right ? right_knees[seg + 1] : left_knees[seg + 1];
        if (y1 >= y0) begin
            return t_duty'(y0 + (offs * (y1 - y0)) / 10);
        end
        return t_duty'(y0 - (offs * (y0 - y1)) / 10);
    endfunction

    function automatic t_drive bridge_and_duty(input t_cmd cmd, input t_spd spd);
        t_drive d;
        t_duty  dl;
        t_duty  dr;
        dl = curve_duty(1'b0, spd);
        dr = curve_duty(1'b1, spd);
        d  = '0;
        case (cmd)
            CMD_FORWARD: begin
                d.a_in1 = 1'b1; d.b_in1 = 1'b1; d.duty_a = dr; d.duty_b = dl;
            end
            CMD_BACKWARD: begin
                d.a_in2 = 1'b1; d.b_in2 = 1'b1; d.duty_a = dl; d.duty_b = dr;
            end
            CMD_LEFT: begin
                d.b_in1 = 1'b1; d.duty_b = dr;
            end
            CMD_RIGHT: begin
                d.a_in1 = 1'b1; d.duty_a = dl;
            end
            default: begin
            end
        endcase
        return d;
    endfunction

    // Present one request, in bursts with random gaps, and log its drive once taken
    task automatic send_request(input t_cmd cmd, input t_spd spd, input t_drive want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_speed_pct <= spd;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_drive_q.push_back(want);
    endtask

    // Hold off new requests until every outstanding drive has come back
    task automatic drain_pending();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_drive_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Receiver stall pattern: rotates through always ready, coin flip, mostly stalled, periodic
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0:    i_ready <= 1'b1;
            2'd1:    i_ready <= ($urandom_range(0, 1) == 1);
            2'd2:    i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= (stall_phase[2:0] < 3'd5);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got_drive = '{o_a_in1, o_a_in2, o_b_in1, o_b_in2, o_duty_a, o_duty_b};
            if (pending_drive_q.size() == 0) begin
                $error("result with no request pending");
                fail_count++;
            end else begin
                want_drive = pending_drive_q.pop_front();
                check_field("a_in1",  int'(want_drive.a_in1),  int'(got_drive.a_in1));
                check_field("a_in2",  int'(want_drive.a_in2),  int'(got_drive.a_in2));
                check_field("b_in1",  int'(want_drive.b_in1),  int'(got_drive.b_in1));
                check_field("b_in2",  int'(want_drive.b_in2),  int'(got_drive.b_in2));
                check_field("duty_a", int'(want_drive.duty_a), int'(got_drive.duty_a));
                check_field("duty_b", int'(want_drive.duty_b), int'(got_drive.duty_b));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dual_motor_speed_curve_drive verification failed");
            $finish;
        end
    end

    initial begin
        t_cmd cmd;
        t_spd spd;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < PROBE_COUNT; i++) begin
            send_request(probe_tab[i].cmd, probe_tab[i].spd,
                         probe_tab[i].typed ? probe_tab[i].want
                                            : bridge_and_duty(probe_tab[i].cmd,
                                                              probe_tab[i].spd));
        end
        drain_pending();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 2) begin
                drain_pending();
            end
            cmd = t_cmd'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0, 1:    spd = t_spd'($urandom_range(100, 255));
                2, 3:    spd = t_spd'(10 * $urandom_range(0, 10));
                default: spd = t_spd'($urandom_range(0, 99));
            endcase
            send_request(cmd, spd, bridge_and_duty(cmd, spd));
        end
        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("dual_motor_speed_curve_drive verification clean");
        end else begin
            $display("dual_motor_speed_curve_drive verification failed");
        end
        $finish;
    end

endmodule
